[hdl/cscorr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cscorr_pkg: shared types and constants
// Item queue layout, function codes and output widths of the correlator.
// ----------------------------------------------------------------------------
package cscorr_pkg;

	localparam int FUNC_W = 1;
	localparam int IDX_W  = 6;
	localparam int MAG_W  = 38;
	localparam int LAG_W  = 16;
	localparam int TAPS_W = 7;
	localparam int CNT_W  = 16;

	// Sample and tap width, fixed by the stream layout
	localparam int SAMPLE_BITS = 16;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam logic REG_TAPS  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	// Classified request from the front end to the back end
	typedef struct packed {
		logic                   is_load;
		logic [5:0]             tap_index;
		logic [SAMPLE_BITS-1:0] val_a;
		logic [SAMPLE_BITS-1:0] val_b;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_SQUARE,
		ST_SQRT,
		ST_OUT
	} be_state_t;

endpackage
`default_nettype wire

[hdl/cscorr_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cscorr_front: input side
// Accepts requests and queues them as classified commands for the back end.
// ----------------------------------------------------------------------------
module cscorr_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [71:0]         in_data,
	output logic                cmd_valid,
	input  wire                 cmd_ready,
	output cscorr_pkg::cmd_t    cmd
);

	localparam int DEPTH = 2;

	cscorr_pkg::cmd_t q_mem_q [DEPTH];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	cscorr_pkg::cmd_t in_cmd;
	logic             push, pop;

	always_comb begin
		in_cmd.is_load   = (in_data[0] == cscorr_pkg::FUNC_LOAD);
		in_cmd.tap_index = in_data[6:1];
		if (in_data[0] == cscorr_pkg::FUNC_LOAD) begin
			in_cmd.val_a = in_data[22:7];
			in_cmd.val_b = in_data[38:23];
		end else begin
			in_cmd.val_a = in_data[54:39];
			in_cmd.val_b = in_data[70:55];
		end
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
	a_count_move: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
`endif

endmodule
`default_nettype wire

[hdl/cscorr_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cscorr_back: correlation engine
// Sample window, reference memory, serial MAC, power and bitwise square root.
// ----------------------------------------------------------------------------
module cscorr_back #(
	parameter int MAX_TAPS    = 64
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cmd_valid,
	output logic                      cmd_ready,
	input  cscorr_pkg::cmd_t          cmd,
	input  wire  [6:0]                taps_cfg,
	input  wire  [15:0]               count_cfg,
	output logic                      res_valid,
	input  wire                       res_ready,
	output logic [cscorr_pkg::MAG_W-1:0] res_mag,
	output logic [cscorr_pkg::LAG_W-1:0] res_lag,
	output logic                      res_last
);

	localparam int SAMPLE_BITS = cscorr_pkg::SAMPLE_BITS;
	localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CW   = $clog2(MAX_TAPS + 1);
	localparam int PW   = 2 * SAMPLE_BITS + 1;
	localparam int ACCW = PW + CW + 1;
	localparam int SQW  = 2 * ACCW;
	localparam int RW   = ACCW + 1;
	localparam int HW   = (ACCW + 1) / 2;
	localparam int NIT  = SQW / 2;
	localparam int RBW  = $clog2(NIT);
	localparam int REMW = RW + 2;
	localparam int MIDX = MAX_TAPS - 1;
	localparam logic [RW-1:0]  MAG_MAX = RW'((65'd1 << 38) - 65'd1);

	// Window is a circular memory; newest sample at wptr_q - 1
	logic signed [SAMPLE_BITS-1:0] win_i_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] win_q_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] ref_r_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] ref_c_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0] win_vld_q;

	cscorr_pkg::be_state_t state_q, state_d;
	logic [AW-1:0]  wptr_q, rd_w_q;
	logic [CW-1:0]  fill_q, k_q, taps_q;
	logic [15:0]    lag_q;
	logic           lastf_q;
	logic           rd_vld_s1;
	logic signed [SAMPLE_BITS-1:0] xi_s1, xq_s1, cr_s1, ci_s1;
	logic signed [ACCW-1:0] re_q, im_q;
	logic [SQW-1:0] pow_q;
	logic [RW-1:0]  root_q;
	logic [REMW-1:0] rem_q;
	logic [RBW-1:0] bit_q;
	logic [2:0]     sq_ph_q;
	logic [ACCW-1:0] abs_q;
	logic [SQW-1:0] sqacc_q;

	logic [CW-1:0]  taps_eff;
	logic [CW-1:0]  fill_next;
	logic [15:0]    frame_eff;
	logic           mac_done;
	logic [2*HW-1:0] abs_x;
	logic [HW-1:0]  mul_a, mul_b;
	logic [2*HW-1:0] pprod;
	logic [SQW-1:0] pterm;
	logic [REMW-1:0] rem_sh, trial;
	logic           do_load, do_sample;

	always_comb begin
		if (taps_cfg == 7'd0) begin
			taps_eff = CW'(1);
		end else if ({25'd0, taps_cfg} > 32'(MAX_TAPS)) begin
			taps_eff = CW'(MAX_TAPS);
		end else begin
			taps_eff = CW'(taps_cfg);
		end
		frame_eff = (count_cfg == 16'd0) ? 16'd1 : count_cfg;
		fill_next = (fill_q == CW'(MAX_TAPS)) ? fill_q : fill_q + CW'(1);
	end

	assign cmd_ready = (state_q == cscorr_pkg::ST_IDLE);
	assign do_load   = cmd_valid && cmd_ready && cmd.is_load;
	assign do_sample = cmd_valid && cmd_ready && !cmd.is_load;
	assign mac_done  = (k_q == taps_q) && !rd_vld_s1;

	// Squares from half-width partial products, one per cycle:
	// lo*lo, 2*lo*hi, hi*hi for the real part, then again for the imaginary
	always_comb begin
		abs_x = (2*HW)'(abs_q);
		case (sq_ph_q)
			3'd1, 3'd4: begin
				mul_a = abs_x[HW-1:0];
				mul_b = abs_x[HW-1:0];
			end
			3'd2, 3'd5: begin
				mul_a = abs_x[HW-1:0];
				mul_b = abs_x[2*HW-1:HW];
			end
			default: begin
				mul_a = abs_x[2*HW-1:HW];
				mul_b = abs_x[2*HW-1:HW];
			end
		endcase
		pprod = mul_a * mul_b;
		case (sq_ph_q)
			3'd2, 3'd5: pterm = SQW'(pprod) << (HW + 1);
			3'd3, 3'd6: pterm = SQW'(pprod) << (2 * HW);
			default:    pterm = SQW'(pprod);
		endcase
		// digit-by-digit root: two radicand bits per step
		rem_sh = {rem_q[REMW-3:0], pow_q[SQW-1:SQW-2]};
		trial  = {root_q, 2'b01};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cscorr_pkg::ST_IDLE: begin
				if (do_sample && fill_next >= taps_eff) begin
					state_d = cscorr_pkg::ST_MAC;
				end
			end
			cscorr_pkg::ST_MAC: begin
				if (mac_done) begin
					state_d = cscorr_pkg::ST_SQUARE;
				end
			end
			cscorr_pkg::ST_SQUARE: begin
				if (sq_ph_q == 3'd6) begin
					state_d = cscorr_pkg::ST_SQRT;
				end
			end
			cscorr_pkg::ST_SQRT: begin
				if (bit_q == '0) begin
					state_d = cscorr_pkg::ST_OUT;
				end
			end
			cscorr_pkg::ST_OUT: begin
				if (res_ready) begin
					state_d = cscorr_pkg::ST_IDLE;
				end
			end
			default: state_d = cscorr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		res_valid = (state_q == cscorr_pkg::ST_OUT);
		res_mag   = (root_q > MAG_MAX) ? MAG_MAX[37:0] : root_q[37:0];
		res_lag   = lag_q;
		res_last  = lastf_q;
	end

	// Memories
	always_ff @(posedge clk) begin
		if (do_sample) begin
			win_i_mem[wptr_q] <= cmd.val_a[SAMPLE_BITS-1:0];
			win_q_mem[wptr_q] <= cmd.val_b[SAMPLE_BITS-1:0];
		end
		if (do_load && 32'(cmd.tap_index) < 32'(MAX_TAPS)) begin
			ref_r_mem[AW'(cmd.tap_index)] <= cmd.val_a[SAMPLE_BITS-1:0];
			ref_c_mem[AW'(cmd.tap_index)] <= cmd.val_b[SAMPLE_BITS-1:0];
		end
		xi_s1 <= win_vld_q[rd_w_q] ? win_i_mem[rd_w_q] : '0;
		xq_s1 <= win_vld_q[rd_w_q] ? win_q_mem[rd_w_q] : '0;
		cr_s1 <= ref_r_mem[AW'(k_q)];
		ci_s1 <= ref_c_mem[AW'(k_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cscorr_pkg::ST_IDLE;
			wptr_q    <= '0;
			win_vld_q <= '0;
			fill_q    <= '0;
			lag_q     <= '0;
			lastf_q   <= 1'b0;
			k_q       <= '0;
			taps_q    <= '0;
			rd_w_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= 1'b0;
			if (do_sample) begin
				win_vld_q[wptr_q] <= 1'b1;
				wptr_q <= (wptr_q == AW'(MIDX)) ? '0 : wptr_q + AW'(1);
				fill_q <= fill_next;
				if (fill_next >= taps_eff) begin
					taps_q <= taps_eff;
					k_q    <= '0;
					// oldest of the used window sits taps - 1 back from the newest
					rd_w_q <= (32'(wptr_q) + 32'(MAX_TAPS) + 1 >= 32'(taps_eff)
						+ 32'(MAX_TAPS))
						? AW'(32'(wptr_q) + 1 - 32'(taps_eff))
						: AW'(32'(wptr_q) + 1 + 32'(MAX_TAPS) - 32'(taps_eff));
					lastf_q <= (32'(lag_q) + 1 >= 32'(frame_eff));
				end
			end
			if (state_q == cscorr_pkg::ST_MAC && k_q != taps_q) begin
				k_q       <= k_q + CW'(1);
				rd_vld_s1 <= 1'b1;
				rd_w_q    <= (rd_w_q == AW'(MIDX)) ? '0 : rd_w_q + AW'(1);
			end
			if (state_q == cscorr_pkg::ST_OUT && res_ready) begin
				if (lastf_q) begin
					lag_q  <= '0;
					fill_q <= '0;
				end else begin
					lag_q <= lag_q + 16'd1;
				end
			end
		end
	end

	// Serial MAC, one tap per cycle; then squares and bitwise root
	always_ff @(posedge clk) begin
		if (state_q == cscorr_pkg::ST_IDLE) begin
			re_q <= '0;
			im_q <= '0;
			sq_ph_q <= 3'd0;
		end
		if (rd_vld_s1) begin
			re_q <= re_q + ACCW'(xi_s1 * cr_s1) + ACCW'(xq_s1 * ci_s1);
			im_q <= im_q + ACCW'(xq_s1 * cr_s1) - ACCW'(xi_s1 * ci_s1);
		end
		if (state_q == cscorr_pkg::ST_SQUARE) begin
			sq_ph_q <= sq_ph_q + 3'd1;
			case (sq_ph_q)
				3'd0: begin
					abs_q   <= re_q[ACCW-1] ? ACCW'(-re_q) : ACCW'(re_q);
					sqacc_q <= '0;
				end
				3'd3: begin
					sqacc_q <= sqacc_q + pterm;
					abs_q   <= im_q[ACCW-1] ? ACCW'(-im_q) : ACCW'(im_q);
				end
				3'd6: begin
					pow_q  <= sqacc_q + pterm;
					root_q <= '0;
					rem_q  <= '0;
					bit_q  <= RBW'(NIT - 1);
				end
				default: begin
					sqacc_q <= sqacc_q + pterm;
				end
			endcase
		end
		if (state_q == cscorr_pkg::ST_SQRT) begin
			pow_q <= pow_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[RW-2:0], 1'b0};
			end
			if (bit_q != '0) begin
				bit_q <= bit_q - RBW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != cscorr_pkg::ST_IDLE |-> !cmd_ready) else $error("request taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_mag)) else $error("result lost");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= taps_q) else $error("tap counter overrun");
`endif

endmodule
`default_nettype wire

[hdl/complex_sliding_correlator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// complex_sliding_correlator_unit: complex sliding correlator, magnitude out
// Top level: configuration registers, front queue and correlation engine.
// ----------------------------------------------------------------------------
// One request at a time reaches the engine from the front queue while the engine
// is idle: a tap load or a sample that does not complete the window is taken and
// leaves the engine idle; a sample that yields a result runs serial multiply-
// accumulate (one tap per cycle from the window and reference memories), then the
// squares (one half-width partial product a cycle) and the square root (two
// radicand bits a cycle); the result is then offered and the engine waits until
// it is taken. A two-entry queue lets the source run ahead of the engine.
module complex_sliding_correlator_unit #(
	parameter int MAX_TAPS    = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// func, tap_index, tap_real, tap_imag, sample_i, sample_q, zero pad
	input  wire  [71:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// magnitude, lag_index, zero pad
	output logic [55:0] m_tdata,
	output logic        m_tlast,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data
);

	logic [6:0]       taps_q;
	logic [15:0]      count_q;
	logic             cmd_valid, cmd_ready;
	cscorr_pkg::cmd_t cmd;
	logic [37:0]      mag;
	logic [15:0]      lag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q  <= 7'd1;
			count_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				cscorr_pkg::REG_TAPS:  taps_q  <= cfg_data[6:0];
				cscorr_pkg::REG_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cscorr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	cscorr_back #(.MAX_TAPS(MAX_TAPS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.taps_cfg(taps_q), .count_cfg(count_q),
		.res_valid(m_tvalid), .res_ready(m_tready),
		.res_mag(mag), .res_lag(lag), .res_last(m_tlast)
	);

	assign m_tdata = {2'b00, lag, mag};

endmodule
`default_nettype wire

[sim/complex_sliding_correlator_unit_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// complex_sliding_correlator_unit_test: self-checking bench for the correlator
// Streams tap loads and I/Q samples under random back-pressure, predicts each
// magnitude, lag and frame end, and compares every result in order.
// ----------------------------------------------------------------------------
module complex_sliding_correlator_unit_test;

	localparam int NTAPS     = 64;
	localparam int SETTLE    = 150;
	localparam int WDOG_MAX  = 20000;

	typedef struct {
		logic [cscorr_pkg::MAG_W-1:0] mag;
		logic [cscorr_pkg::LAG_W-1:0] lag;
		logic                         last;
	} corr_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	complex_sliding_correlator_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic signed [15:0] win_i [NTAPS];
	logic signed [15:0] win_q [NTAPS];
	logic signed [15:0] tap_re [NTAPS];
	logic signed [15:0] tap_im [NTAPS];
	int unsigned fill_cnt;
	int unsigned lag_cnt;
	int unsigned taps_reg;
	int unsigned frame_reg;

	logic [71:0] pending_q [$];
	corr_res_t   expected_q [$];
	int          n_errors;
	int          src_idle_pct;
	int          snk_idle_pct;
	logic        sent;
	int          quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [37:0] corr_magnitude(int unsigned taps);
		logic signed [47:0] re;
		logic signed [47:0] im;
		logic [47:0] ar;
		logic [47:0] ai;
		logic [95:0] pw;
		logic [47:0] root;
		logic [47:0] cand;
		int base;
		re = '0;
		im = '0;
		base = NTAPS - taps;
		for (int k = 0; k < taps; k++) begin
			re = re + win_i[base+k] * tap_re[k] + win_q[base+k] * tap_im[k];
			im = im + win_q[base+k] * tap_re[k] - win_i[base+k] * tap_im[k];
		end
		ar = re[47] ? -re : re;
		ai = im[47] ? -im : im;
		pw = {48'b0, ar} * {48'b0, ar} + {48'b0, ai} * {48'b0, ai};
		root = '0;
		for (int b = 47; b >= 0; b--) begin
			cand = root | (48'd1 << b);
			if ({48'b0, cand} * {48'b0, cand} <= pw)
				root = cand;
		end
		if (root > 48'h3F_FFFF_FFFF)
			root = 48'h3F_FFFF_FFFF;
		return root[37:0];
	endfunction

	task automatic correlate_request(input logic [71:0] d);
		int unsigned taps;
		int unsigned frame;
		corr_res_t r;
		taps  = (taps_reg == 0) ? 1 : (taps_reg > NTAPS ? NTAPS : taps_reg);
		frame = (frame_reg == 0) ? 1 : frame_reg;
		if (d[0] == cscorr_pkg::FUNC_LOAD) begin
			tap_re[d[6:1]] = d[22:7];
			tap_im[d[6:1]] = d[38:23];
			return;
		end
		for (int k = 0; k < NTAPS - 1; k++) begin
			win_i[k] = win_i[k+1];
			win_q[k] = win_q[k+1];
		end
		win_i[NTAPS-1] = d[54:39];
		win_q[NTAPS-1] = d[70:55];
		if (fill_cnt < NTAPS)
			fill_cnt++;
		if (fill_cnt < taps)
			return;
		r.mag = corr_magnitude(taps);
		r.lag = lag_cnt[15:0];
		if (lag_cnt + 1 >= frame) begin
			r.last = 1'b1;
			lag_cnt = 0;
			fill_cnt = 0;
		end else begin
			r.last = 1'b0;
			lag_cnt++;
		end
		expected_q.push_back(r);
	endtask

	function automatic void push_load(logic [5:0] idx, logic [15:0] re, logic [15:0] im);
		logic [71:0] d;
		d = 72'({$urandom, $urandom, $urandom});
		d[0] = cscorr_pkg::FUNC_LOAD;
		d[6:1] = idx;
		d[22:7] = re;
		d[38:23] = im;
		d[71] = 1'b0;
		pending_q.push_back(d);
	endfunction

	function automatic void push_sample(logic [15:0] si, logic [15:0] sq);
		logic [71:0] d;
		d = 72'({$urandom, $urandom, $urandom});
		d[0] = cscorr_pkg::FUNC_SAMPLE;
		d[54:39] = si;
		d[70:55] = sq;
		d[71] = 1'b0;
		pending_q.push_back(d);
	endfunction

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == cscorr_pkg::REG_TAPS)
			taps_reg = val[6:0];
		else
			frame_reg = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
			if (!s_tvalid || sent) begin
				if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					s_tdata  <= pending_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// input capture, result check and watchdog
	always @(posedge clk) begin
		corr_res_t e;
		sent = arst_n && s_tvalid && s_tready;
		if (sent)
			correlate_request(s_tdata);
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result: magnitude %0d lag %0d", m_tdata[37:0], m_tdata[53:38]);
				n_errors++;
			end else begin
				e = expected_q.pop_front();
				if (m_tdata[37:0] !== e.mag) begin
					$error("magnitude: expected %0d, got %0d", e.mag, m_tdata[37:0]);
					n_errors++;
				end
				if (m_tdata[53:38] !== e.lag) begin
					$error("lag_index: expected %0d, got %0d", e.lag, m_tdata[53:38]);
					n_errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, m_tlast);
					n_errors++;
				end
			end
		end
		if (sent || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles = 0;
		else if (++quiet_cycles >= WDOG_MAX) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		// taps register, frame register, per phase; includes the out-of-range values
		static int unsigned plan_taps [9]  = '{1, 0, 64, 127, 8, 13, 64, 2, 33};
		static int unsigned plan_frame [9] = '{1, 3, 5, 0, 65535, 4, 2, 9, 1};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = cscorr_pkg::REG_TAPS;
		cfg_data = '0;
		n_errors = 0;
		quiet_cycles = 0;
		sent = 1'b0;
		src_idle_pct = 33;
		snk_idle_pct = 52;
		for (int k = 0; k < NTAPS; k++) begin
			win_i[k] = '0;
			win_q[k] = '0;
			tap_re[k] = '0;
			tap_im[k] = '0;
		end
		fill_cnt = 0;
		lag_cnt = 0;
		taps_reg = 1;
		frame_reg = 1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every tap written before any sample can read it
		push_load(6'd0, 16'h8000, 16'h8000);
		push_load(6'd1, 16'h7FFF, 16'h7FFF);
		push_load(6'd2, 16'h8000, 16'h7FFF);
		for (int k = 3; k < NTAPS; k++)
			push_load(6'(k), pick_value(), pick_value());
		drain();

		// directed: three taps, frames of four, full-scale, zero and small samples
		write_reg(cscorr_pkg::REG_TAPS, 16'd3);
		write_reg(cscorr_pkg::REG_COUNT, 16'd4);
		push_sample(16'h8000, 16'h8000);
		push_sample(16'h8000, 16'h8000);
		push_sample(16'h8000, 16'h8000);
		push_sample(16'h7FFF, 16'h8000);
		push_sample(16'h0000, 16'h0000);
		push_sample(16'hFFFF, 16'h7FFF);
		push_sample(16'h7FFF, 16'h7FFF);
		push_load(6'd63, 16'h7FFF, 16'h8000);
		push_sample(16'h8000, 16'h7FFF);
		push_sample(16'h0001, 16'hFFFF);
		push_sample(16'h8000, 16'h8000);
		push_sample(16'h8000, 16'h8000);
		push_sample(16'h8000, 16'h8000);
		// tap count changed at a frame boundary
		drain();
		write_reg(cscorr_pkg::REG_TAPS, 16'd5);
		push_sample(16'h7FFF, 16'h0000);
		push_sample(16'h0000, 16'h7FFF);
		drain();

		for (int p = 0; p < 9; p++) begin
			if (p == 3) begin
				src_idle_pct = 52;
				snk_idle_pct = 33;
			end else if (p == 6) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			write_reg(cscorr_pkg::REG_TAPS, 16'(plan_taps[p]));
			write_reg(cscorr_pkg::REG_COUNT, 16'(plan_frame[p]));
			for (int n = 0; n < 110; n++) begin
				if ($urandom_range(0, 99) < 12)
					push_load(6'($urandom), pick_value(), pick_value());
				else
					push_sample(pick_value(), pick_value());
			end
			drain();
		end

		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
hdl/cscorr_pkg.sv
hdl/cscorr_front.sv
hdl/cscorr_back.sv
hdl/complex_sliding_correlator_unit.sv
sim/complex_sliding_correlator_unit_test.sv
